[hdl/assert_macros.svh]
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define WLP_ASSERT_IMPLY(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("wlp assertion failed");

// next-cycle implication, disabled during reset
`define WLP_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("wlp assertion failed");

`endif

[hdl/wlp_pkg.sv]
// types and constants of the windowed latency percentile engine
package wlp_pkg;

  // command codes
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_RANK_LOW  = 2'd0;
  localparam logic [1:0] CFG_RANK_MID  = 2'd1;
  localparam logic [1:0] CFG_RANK_HIGH = 2'd2;

  // rank register resets
  localparam logic [6:0] RANK_LOW_RST  = 7'd50;
  localparam logic [6:0] RANK_MID_RST  = 7'd95;
  localparam logic [6:0] RANK_HIGH_RST = 7'd99;

  // nearest-rank arithmetic
  localparam int PCT_DIV    = 100;
  localparam int RANK_ROUND = 99;
  localparam int NUM_RANKS  = 3;

  // saturation limits
  localparam logic [47:0] CNT_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [62:0] SUM_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic        op;
    logic [31:0] sample;
  } in_t;

  typedef struct packed {
    logic [31:0] pct_low;
    logic [31:0] pct_mid;
    logic [31:0] pct_high;
    logic [31:0] max_seen;
    logic [47:0] lifetime_count;
    logic [62:0] lifetime_sum;
    logic [7:0]  window_fill;
    logic        empty_res;
  } out_t;

  // per-cycle commands broadcast to every cell
  typedef struct packed {
    logic record;
    logic load;
    logic count;
    logic mark;
    logic pick;
  } cell_ctl_t;

endpackage

[hdl/wlp_cell.sv]
// one window cell: holds a sample, counts smaller samples passing by, marks rank hits
module wlp_cell #(
  parameter int WINDOW = 128
) (
  input  logic                                clk,
  input  wlp_pkg::cell_ctl_t                  ctl,
  input  logic                                vld,
  input  logic [31:0]                         value_in,
  input  logic [31:0]                         scan_in,
  input  logic                                scan_vld_in,
  input  logic [wlp_pkg::NUM_RANKS-1:0]       hit_in,
  input  logic [wlp_pkg::NUM_RANKS-1:0][$clog2(WINDOW+1)-1:0] idx,
  output logic [31:0]                         value,
  output logic [31:0]                         scan,
  output logic                                scan_vld,
  output logic [wlp_pkg::NUM_RANKS-1:0]       hit
);

  localparam int CW = $clog2(WINDOW + 1);

  logic [CW-1:0] less;
  logic [CW-1:0] le;

  // window shift on record
  always_ff @(posedge clk) begin
    if (ctl.record) begin
      value <= value_in;
    end
  end

  // scan value rotation and order counting
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      scan     <= value;
      scan_vld <= vld;
      less     <= '0;
      le       <= '0;
    end else if (ctl.count) begin
      scan     <= scan_in;
      scan_vld <= scan_vld_in;
      if (scan_vld && vld) begin
        if (scan < value) begin
          less <= less + CW'(1);
        end
        if (scan <= value) begin
          le <= le + CW'(1);
        end
      end
    end else if (ctl.pick) begin
      scan <= scan_in;
    end
  end

  // rank hit flags: this sample covers sorted position idx
  always_ff @(posedge clk) begin
    if (ctl.mark) begin
      for (int k = 0; k < wlp_pkg::NUM_RANKS; k++) begin
        hit[k] <= vld && (less <= idx[k]) && (le > idx[k]);
      end
    end else if (ctl.pick) begin
      hit <= hit_in;
    end
  end

endmodule

[hdl/wlp_rank.sv]
// serial nearest-rank index unit: ceil(n*p/100)-1 clamped, one rank at a time
module wlp_rank #(
  parameter int WINDOW = 128
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                go,
  input  logic [$clog2(WINDOW+1)-1:0]         n,
  input  logic [wlp_pkg::NUM_RANKS-1:0][6:0]  ranks,
  output logic [wlp_pkg::NUM_RANKS-1:0][$clog2(WINDOW+1)-1:0] idx,
  output logic                                fin
);

  localparam int CW   = $clog2(WINDOW + 1);
  localparam int XMAX = WINDOW * 127 + wlp_pkg::RANK_ROUND;
  localparam int XW   = $clog2(XMAX + 1);
  localparam int RECIP = (2 ** XW) / wlp_pkg::PCT_DIV;
  localparam int MW   = $clog2(RECIP + 1);
  localparam int PW   = XW + MW;
  localparam int SW   = $clog2(wlp_pkg::NUM_RANKS);

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_MUL  = 4'b0010,
    PH_RCP  = 4'b0100,
    PH_FIX  = 4'b1000
  } ph_t;

  ph_t           ph;
  logic [SW-1:0] sel;
  logic [XW-1:0] x;
  logic [PW-1:0] prod;

  logic [CW+6:0] np;
  logic [XW-1:0] q_est;
  logic [XW-1:0] q_mul;
  logic [XW-1:0] r;
  logic [XW-1:0] q;
  logic [XW-1:0] pos;
  logic [XW-1:0] n_ext;
  logic [CW-1:0] idx_next;

  // numerator, quotient estimate by reciprocal and one-step correction
  always_comb begin
    np       = (CW + 7)'(n) * (CW + 7)'(ranks[sel]);
    n_ext    = XW'(n);
    q_est    = XW'(prod >> XW);
    q_mul    = XW'(q_est * XW'(wlp_pkg::PCT_DIV));
    r        = x - q_mul;
    q        = (r >= XW'(wlp_pkg::PCT_DIV)) ? q_est + XW'(1) : q_est;
    pos      = (q == '0) ? '0 : q - XW'(1);
    if (n == '0) begin
      idx_next = '0;
    end else if (pos >= n_ext) begin
      idx_next = n - CW'(1);
    end else begin
      idx_next = CW'(pos);
    end
  end

  // sequencer over the three ranks
  always_ff @(posedge clk) begin
    if (rst) begin
      ph  <= PH_IDLE;
      sel <= '0;
      fin <= 1'b0;
    end else begin
      fin <= 1'b0;
      unique case (ph)
        PH_IDLE: begin
          if (go) begin
            ph  <= PH_MUL;
            sel <= '0;
          end
        end
        PH_MUL: begin
          ph <= PH_RCP;
        end
        PH_RCP: begin
          ph <= PH_FIX;
        end
        PH_FIX: begin
          if (sel == SW'(wlp_pkg::NUM_RANKS - 1)) begin
            ph  <= PH_IDLE;
            fin <= 1'b1;
          end else begin
            ph  <= PH_MUL;
            sel <= sel + SW'(1);
          end
        end
        default: begin
          ph <= PH_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (ph == PH_MUL) begin
      x <= XW'(np) + XW'(wlp_pkg::RANK_ROUND);
    end
    if (ph == PH_RCP) begin
      prod <= PW'(x) * PW'(RECIP);
    end
    if (ph == PH_FIX) begin
      idx[sel] <= idx_next;
    end
  end

endmodule

[hdl/windowed_latency_percentiles.sv]
// top level of the windowed latency percentile engine
// A record transaction shifts the sample into a chain of WINDOW cells and updates the count,
// sum and maximum; busy never rises. A report transaction keeps busy high while the serial
// rank index unit works out each rank in turn and raises its finish flag, the cells load, the
// scan value rotates once around the cell chain while each cell counts smaller samples, the
// cells mark rank hits, and the marked samples rotate past the chain tap. Done then pulses for
// one cycle with the result. The result register holds until the next report is accepted, and
// done cannot be stalled. An empty window reports zero percentiles with empty_res set. No
// clearing pass follows reset.
module windowed_latency_percentiles #(
  parameter int WINDOW = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  wlp_pkg::in_t     cmd,
  output logic             done,
  output wlp_pkg::out_t    result,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_addr,
  input  logic [6:0]       cfg_data
);

  localparam int CW = $clog2(WINDOW + 1);
  localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int NR = wlp_pkg::NUM_RANKS;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_RANK  = 6'b000010,
    ST_LOAD  = 6'b000100,
    ST_COUNT = 6'b001000,
    ST_MARK  = 6'b010000,
    ST_PICK  = 6'b100000
  } state_t;

  state_t state;
  logic [IW-1:0] cnt;

  logic [6:0] rank_low;
  logic [6:0] rank_mid;
  logic [6:0] rank_high;

  logic [CW-1:0] fill_count;
  logic [47:0]   total_samples;
  logic [62:0]   total_time;
  logic [31:0]   peak_sample;

  logic accept;
  logic rank_go;
  logic rank_fin;
  logic [NR-1:0][6:0]    ranks;
  logic [NR-1:0][CW-1:0] idx;
  logic [63:0]           sum_ext;

  wlp_pkg::cell_ctl_t ctl;

  logic [31:0]   val      [WINDOW];
  logic [31:0]   scan     [WINDOW];
  logic          scan_vld [WINDOW];
  logic [NR-1:0] hit      [WINDOW];

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign rank_go = accept && (cmd.op == wlp_pkg::OP_REPORT);
  assign ranks   = {rank_high, rank_mid, rank_low};
  assign sum_ext = {1'b0, total_time} + {32'b0, cmd.sample};

  // cell commands
  always_comb begin
    ctl.record = accept && (cmd.op == wlp_pkg::OP_RECORD);
    ctl.load   = (state == ST_LOAD);
    ctl.count  = (state == ST_COUNT);
    ctl.mark   = (state == ST_MARK);
    ctl.pick   = (state == ST_PICK);
  end

  // rank configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rank_low  <= wlp_pkg::RANK_LOW_RST;
      rank_mid  <= wlp_pkg::RANK_MID_RST;
      rank_high <= wlp_pkg::RANK_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        wlp_pkg::CFG_RANK_LOW:  rank_low  <= cfg_data;
        wlp_pkg::CFG_RANK_MID:  rank_mid  <= cfg_data;
        wlp_pkg::CFG_RANK_HIGH: rank_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // lifetime statistics and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      total_samples <= '0;
      total_time    <= '0;
      peak_sample   <= '0;
    end else if (ctl.record) begin
      if (fill_count != CW'(WINDOW)) begin
        fill_count <= fill_count + CW'(1);
      end
      if (total_samples != wlp_pkg::CNT_MAX) begin
        total_samples <= total_samples + 48'd1;
      end
      if (sum_ext > {1'b0, wlp_pkg::SUM_MAX}) begin
        total_time <= wlp_pkg::SUM_MAX;
      end else begin
        total_time <= sum_ext[62:0];
      end
      if (cmd.sample > peak_sample) begin
        peak_sample <= cmd.sample;
      end
    end
  end

  // report sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (rank_go) begin
            state <= ST_RANK;
          end
        end
        ST_RANK: begin
          if (rank_fin) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          state <= ST_COUNT;
          cnt   <= '0;
        end
        ST_COUNT: begin
          if (cnt == IW'(WINDOW - 1)) begin
            state <= ST_MARK;
          end else begin
            cnt <= cnt + IW'(1);
          end
        end
        ST_MARK: begin
          state <= ST_PICK;
          cnt   <= '0;
        end
        ST_PICK: begin
          if (cnt == IW'(WINDOW - 1)) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end else begin
            cnt <= cnt + IW'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result register: fixed fields at accept, percentiles from the chain tap
  always_ff @(posedge clk) begin
    if (rank_go) begin
      result.pct_low        <= '0;
      result.pct_mid        <= '0;
      result.pct_high       <= '0;
      result.max_seen       <= peak_sample;
      result.lifetime_count <= total_samples;
      result.lifetime_sum   <= total_time;
      result.window_fill    <= 8'(fill_count);
      result.empty_res      <= (fill_count == '0);
    end else if (ctl.pick) begin
      if (hit[WINDOW-1][0]) begin
        result.pct_low <= scan[WINDOW-1];
      end
      if (hit[WINDOW-1][1]) begin
        result.pct_mid <= scan[WINDOW-1];
      end
      if (hit[WINDOW-1][2]) begin
        result.pct_high <= scan[WINDOW-1];
      end
    end
  end

  // rank index unit
  wlp_rank #(
    .WINDOW (WINDOW)
  ) u_rank (
    .clk   (clk),
    .rst   (rst),
    .go    (rank_go),
    .n     (fill_count),
    .ranks (ranks),
    .idx   (idx),
    .fin   (rank_fin)
  );

  // chain of window cells, scan and hit flags wrap from the last cell to the first
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    localparam int PREV = (i == 0) ? WINDOW - 1 : i - 1;
    logic [31:0] value_in;
    logic        vld;

    assign value_in = (i == 0) ? cmd.sample : val[PREV];
    assign vld      = (fill_count > CW'(i));

    wlp_cell #(
      .WINDOW (WINDOW)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .vld         (vld),
      .value_in    (value_in),
      .scan_in     (scan[PREV]),
      .scan_vld_in (scan_vld[PREV]),
      .hit_in      (hit[PREV]),
      .idx         (idx),
      .value       (val[i]),
      .scan        (scan[i]),
      .scan_vld    (scan_vld[i]),
      .hit         (hit[i])
    );
  end

endmodule

[hdl/wlp_checker.sv]
// port-level checker for the windowed latency percentile engine, bound to the top level
`include "assert_macros.svh"

module wlp_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input wlp_pkg::in_t  cmd,
  input logic          done,
  input wlp_pkg::out_t result
);

  logic report_acc;
  logic record_acc;

  assign report_acc = start && !busy && (cmd.op == wlp_pkg::OP_REPORT);
  assign record_acc = start && !busy && (cmd.op == wlp_pkg::OP_RECORD);

  // a report transaction occupies the block
  `WLP_ASSERT_NEXT(a_report_busy, clk, rst, report_acc, busy)
  // a record transaction finishes in its own cycle
  `WLP_ASSERT_NEXT(a_record_quick, clk, rst, record_acc, !busy)
  // a result follows a busy period and frees the block
  `WLP_ASSERT_IMPLY(a_done_after_busy, clk, rst, done, $past(busy) && !busy)
  // an empty window reports zero percentiles
  `WLP_ASSERT_IMPLY(a_empty_zero, clk, rst, done && result.empty_res,
    (result.pct_low == 32'd0) && (result.pct_mid == 32'd0) && (result.pct_high == 32'd0)
    && (result.window_fill == 8'd0))

endmodule

bind windowed_latency_percentiles wlp_checker u_wlp_checker (.*);
